// ===== sv/owbm_pkg.sv =====
// Shared types, codes and constants of the one-wire bus master.
`default_nettype none
package owbm_pkg;

    // Widths of the timing registers and of the configuration index, and the number of timing registers.
    localparam int TIME_W = 10;
    localparam int NUM_REGS = 8;
    localparam int CFG_IDX_W = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_ONE_LOW = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_ONE_HIGH = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_ZERO_LOW = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_ZERO_HIGH = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_READ_LOW = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE_WAIT = 4'd7;

    typedef logic [TIME_W-1:0] owbm_time_t;
    typedef logic [NUM_REGS-1:0][TIME_W-1:0] owbm_regs_t;

    // Reset values of the timing registers, in microseconds.
    localparam owbm_regs_t REG_DEFAULTS = {
        10'd10,  // read sample wait
        10'd10,  // read low
        10'd10,  // write zero high
        10'd60,  // write zero low
        10'd70,  // write one high
        10'd10,  // write one low
        10'd70,  // presence wait
        10'd480  // reset low
    };

    // Item kinds.
    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_RESET = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_READ  = 2'd3
    } owbm_kind_t;

    // Sequencer phases, one-hot.
    typedef enum logic [7:0] {
        PH_IDLE     = 8'b0000_0001,
        PH_RST_LOW  = 8'b0000_0010,
        PH_RST_WAIT = 8'b0000_0100,
        PH_WR_LOW   = 8'b0000_1000,
        PH_WR_HIGH  = 8'b0001_0000,
        PH_RD_LOW   = 8'b0010_0000,
        PH_RD_WAIT  = 8'b0100_0000,
        PH_RD_TAIL  = 8'b1000_0000
    } owbm_phase_t;

    // One result beat.
    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       device_present;
        logic [7:0] read_data;
    } owbm_result_t;

    // A programmed duration of zero lasts one tick.
    function automatic owbm_time_t at_least_one(input owbm_time_t v);
        return (v == '0) ? owbm_time_t'(1) : v;
    endfunction

endpackage
`default_nettype wire

// ===== sv/owbm_if.sv =====
// Channel interfaces of the one-wire bus master: tick items, results, configuration writes.
`default_nettype none
interface owbm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       line_level;

    modport source (output valid, kind, data_byte, line_level, input ready);
    modport sink (input valid, kind, data_byte, line_level, output ready);
endinterface

interface owbm_out_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       device_present;
    logic [7:0] read_data;

    modport source (output valid, drive_low, busy_res, done_res, device_present, read_data,
                    input ready);
    modport sink (input valid, drive_low, busy_res, done_res, device_present, read_data,
                  output ready);
endinterface

interface owbm_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] index;
    logic [9:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/owbm_seq.sv =====
// Bus sequencer: phase, tick and bit counters, shift byte and one tick of next-state logic.
`default_nettype none
module owbm_seq #(
    parameter int READ_TAIL_US = 60
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   step,
    input  wire [1:0]             kind,
    input  wire [7:0]             data_byte,
    input  wire                   line_level,
    input  owbm_pkg::owbm_regs_t  regs,
    output owbm_pkg::owbm_result_t result
);
    import owbm_pkg::*;

    // Tail of a read slot, trimmed to the counter width.
    localparam owbm_time_t TAIL_LEN = owbm_time_t'(READ_TAIL_US);

    owbm_phase_t phase_reg, phase_next;
    owbm_time_t  tick_count_reg, tick_count_next;
    logic [2:0]  bit_index_reg, bit_index_next;
    logic [7:0]  shift_byte_reg, shift_byte_next;
    logic        presence_reg, presence_next;
    logic [7:0]  read_byte_reg, read_byte_next;

    owbm_phase_t cur_phase;
    owbm_time_t  cur_tick;
    logic [7:0]  cur_shift;
    owbm_time_t  phase_len;
    logic        last_tick;
    logic        drive, busy, done;

    // One tick: optional command start, then advance the current phase.
    always_comb
    begin
        cur_phase       = phase_reg;
        cur_tick        = tick_count_reg;
        bit_index_next  = bit_index_reg;
        cur_shift       = shift_byte_reg;
        presence_next   = presence_reg;
        read_byte_next  = read_byte_reg;
        drive           = 1'b0;
        busy            = 1'b0;
        done            = 1'b0;
        phase_len       = owbm_time_t'(1);
        last_tick       = 1'b0;

        // A command is taken only while idle; the start tick is the first phase tick.
        if (phase_reg == PH_IDLE && owbm_kind_t'(kind) != KIND_TICK)
        begin
            cur_tick       = '0;
            bit_index_next = '0;
            case (owbm_kind_t'(kind))
                KIND_RESET: cur_phase = PH_RST_LOW;
                KIND_WRITE:
                begin
                    cur_phase = PH_WR_LOW;
                    cur_shift = data_byte;
                end
                default:
                begin
                    cur_phase = PH_RD_LOW;
                    cur_shift = '0;
                end
            endcase
        end

        phase_next      = cur_phase;
        tick_count_next = cur_tick;
        shift_byte_next = cur_shift;

        // Length of the current phase from the timing registers.
        case (cur_phase)
            PH_RST_LOW:  phase_len = at_least_one(regs[REG_RESET_LOW[2:0]]);
            PH_RST_WAIT: phase_len = at_least_one(regs[REG_PRESENCE_WAIT[2:0]]);
            PH_WR_LOW:   phase_len = at_least_one(cur_shift[0] ? regs[REG_WRITE_ONE_LOW[2:0]]
                                                               : regs[REG_WRITE_ZERO_LOW[2:0]]);
            PH_WR_HIGH:  phase_len = at_least_one(cur_shift[0] ? regs[REG_WRITE_ONE_HIGH[2:0]]
                                                               : regs[REG_WRITE_ZERO_HIGH[2:0]]);
            PH_RD_LOW:   phase_len = at_least_one(regs[REG_READ_LOW[2:0]]);
            PH_RD_WAIT:  phase_len = at_least_one(regs[REG_READ_SAMPLE_WAIT[2:0]]);
            PH_RD_TAIL:  phase_len = at_least_one(TAIL_LEN);
            default:     phase_len = owbm_time_t'(1);
        endcase

        if (cur_phase != PH_IDLE)
        begin
            last_tick = ({1'b0, cur_tick} + 11'd1) >= {1'b0, phase_len};
            busy      = 1'b1;
            drive     = (cur_phase == PH_RST_LOW) || (cur_phase == PH_WR_LOW)
                        || (cur_phase == PH_RD_LOW);
            tick_count_next = cur_tick + owbm_time_t'(1);

            // Phase transitions on the last tick of a phase.
            if (last_tick)
            begin
                tick_count_next = '0;
                case (cur_phase)
                    PH_RST_LOW: phase_next = PH_RST_WAIT;
                    PH_RST_WAIT:
                    begin
                        presence_next = ~line_level;
                        done          = 1'b1;
                        phase_next    = PH_IDLE;
                    end
                    PH_WR_LOW: phase_next = PH_WR_HIGH;
                    PH_WR_HIGH:
                    begin
                        shift_byte_next = {1'b0, cur_shift[7:1]};
                        if (bit_index_reg == 3'd7 || bit_index_next == 3'd7)
                        begin
                            done           = 1'b1;
                            phase_next     = PH_IDLE;
                            bit_index_next = '0;
                        end
                        else
                        begin
                            bit_index_next = bit_index_next + 3'd1;
                            phase_next     = PH_WR_LOW;
                        end
                    end
                    PH_RD_LOW: phase_next = PH_RD_WAIT;
                    PH_RD_WAIT:
                    begin
                        shift_byte_next = {line_level, cur_shift[7:1]};
                        phase_next      = PH_RD_TAIL;
                    end
                    PH_RD_TAIL:
                    begin
                        if (bit_index_next == 3'd7)
                        begin
                            read_byte_next = cur_shift;
                            done           = 1'b1;
                            phase_next     = PH_IDLE;
                            bit_index_next = '0;
                        end
                        else
                        begin
                            bit_index_next = bit_index_next + 3'd1;
                            phase_next     = PH_RD_LOW;
                        end
                    end
                    default: phase_next = PH_IDLE;
                endcase
            end
        end
    end

    // Result of this tick, with the status after it.
    always_comb
    begin
        result.drive_low      = drive;
        result.busy_res       = busy;
        result.done_res       = done;
        result.device_present = presence_next;
        result.read_data      = read_byte_next;
    end

    // Sequencer state advances once per processed tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            tick_count_reg <= '0;
            bit_index_reg  <= '0;
            shift_byte_reg <= '0;
            presence_reg   <= 1'b0;
            read_byte_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            bit_index_reg  <= bit_index_next;
            shift_byte_reg <= shift_byte_next;
            presence_reg   <= presence_next;
            read_byte_reg  <= read_byte_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/one_wire_bus_master_core.sv =====
// Top level of the one-wire bus master: input register, timing registers, sequencer, result register.
//
//  channel  | role   | beat
//  ---------+--------+-----------------------------------------------------------
//  in_item  | sink   | kind, data_byte, line_level: one microsecond tick
//  out_item | source | drive_low, busy_res, done_res, device_present, read_data
//  cfg      | sink   | index, data: write of one timing register
//
// Each tick beat yields one result beat; with both sides flowing a beat is taken
// every cycle. Its beat passes the input register, then the result register, and the
// result is offered from the result register. The sequencer state is updated in the
// cycle a beat moves from the input register to the result register. Reset clears
// the sequencer and loads the default timings. A stalled result register holds the
// beat in the input register and then drops in_item.ready.
`default_nettype none
module one_wire_bus_master_core #(
    parameter int READ_TAIL_US = 60
) (
    input  wire          clk,
    input  wire          rst_n,
    owbm_in_if.sink      in_item,
    owbm_out_if.source   out_item,
    owbm_cfg_if.sink     cfg
);
    import owbm_pkg::*;

    logic         in_valid_reg;
    logic [1:0]   kind_reg;
    logic [7:0]   data_byte_reg;
    logic         line_level_reg;
    logic         out_valid_reg;
    owbm_result_t out_reg;
    owbm_regs_t   regs_reg;
    owbm_result_t step_result;
    logic         step;

    // A beat moves on when the result register is free or being emptied.
    assign step          = in_valid_reg && (!out_valid_reg || out_item.ready);
    assign in_item.ready = !in_valid_reg || step;
    assign cfg.ready     = 1'b1;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_item.ready)
        begin
            in_valid_reg <= in_item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_item.valid && in_item.ready)
        begin
            kind_reg       <= in_item.kind;
            data_byte_reg  <= in_item.data_byte;
            line_level_reg <= in_item.line_level;
        end
    end

    // Timing registers; writes beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= REG_DEFAULTS;
        end
        else if (cfg.valid && cfg.index < CFG_IDX_W'(NUM_REGS))
        begin
            regs_reg[cfg.index[2:0]] <= cfg.data;
        end
    end

    // Sequencer.
    owbm_seq #(
        .READ_TAIL_US (READ_TAIL_US)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .kind       (kind_reg),
        .data_byte  (data_byte_reg),
        .line_level (line_level_reg),
        .regs       (regs_reg),
        .result     (step_result)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_item.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg <= step_result;
        end
    end

    assign out_item.valid          = out_valid_reg;
    assign out_item.drive_low      = out_reg.drive_low;
    assign out_item.busy_res       = out_reg.busy_res;
    assign out_item.done_res       = out_reg.done_res;
    assign out_item.device_present = out_reg.device_present;
    assign out_item.read_data      = out_reg.read_data;

endmodule
`default_nettype wire
